// ===== hw/rtl/wso_pkg.sv =====
// shared constants and helpers for the wavetable sine oscillator
// register indexes, field widths, reset values and the taylor-step tables
// no dependencies
package wso_pkg;

    localparam int unsigned DEF_TABLE_PERIOD = 1024;

    localparam int SAMPLE_W   = 16;
    localparam int PHASE_W    = 32;
    localparam int AMP_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_STEP  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_AMPLITUDE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_PHASE = 2'd2;

    localparam logic signed [AMP_W-1:0] AMP_RESET = 16'sd32767;

    // pi/2 in q30 and 1.0 in q30
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    // horner steps of the sine series, x^11 term first
    localparam int TAYLOR_STEPS = 5;

    function automatic logic [6:0] taylor_div(input logic [2:0] step);
        logic [6:0] d;
        unique case (step)
            3'd0:    d = 7'd110;
            3'd1:    d = 7'd72;
            3'd2:    d = 7'd42;
            3'd3:    d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor) for the same steps
    function automatic logic [31:0] taylor_recip(input logic [2:0] step);
        logic [31:0] m;
        unique case (step)
            3'd0:    m = 32'd39045157;
            3'd1:    m = 32'd59652323;
            3'd2:    m = 32'd102261126;
            3'd3:    m = 32'd214748364;
            default: m = 32'd715827882;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/wso_ram.sv =====
// generic single-write, dual-read ram with registered read data
// depends on nothing
module wso_ram #(
    parameter int unsigned WIDTH  = 16,
    parameter int unsigned DEPTH  = 1025,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hw/rtl/wso_rom_fill.sv =====
// sine table builder: computes every entry after reset with one shared 32x32 multiplier
// and writes it into the table ram; depends on wso_pkg
module wso_rom_fill #(
    parameter int unsigned TABLE_PERIOD = wso_pkg::DEF_TABLE_PERIOD,
    localparam int unsigned ADDR_W = $clog2(TABLE_PERIOD + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    output logic                         o_wr_en,
    output logic [ADDR_W-1:0]            o_wr_addr,
    output logic [wso_pkg::SAMPLE_W-1:0] o_wr_data,
    output logic                         o_done
);

    typedef enum logic [3:0] {
        ST_X, ST_X2, ST_DM, ST_DC, ST_DH, ST_HM, ST_SM, ST_Q, ST_DONE
    } t_fill_state;

    localparam int unsigned REM_W = $clog2(TABLE_PERIOD) + 1;
    localparam logic [31:0]       T_STEP    = 32'((64'd1 << 32) / TABLE_PERIOD);
    localparam logic [REM_W-1:0]  T_REM     = REM_W'((64'd1 << 32) % TABLE_PERIOD);
    localparam logic [REM_W-1:0]  T_DIV     = REM_W'(TABLE_PERIOD);
    localparam logic [2:0]        LAST_STEP = 3'(wso_pkg::TAYLOR_STEPS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_PERIOD);

    t_fill_state       r_state;
    logic [ADDR_W-1:0] r_idx;
    logic [31:0]       r_t;
    logic [REM_W-1:0]  r_trem;
    logic [2:0]        r_k;

    logic [30:0] r_x;
    logic [31:0] r_x2;
    logic [31:0] r_y;
    logic [63:0] r_prod;
    logic [31:0] r_q0;
    logic [7:0]  r_rem;
    logic [30:0] r_h;

    logic [1:0]       quad;
    logic [30:0]      mirror;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      mul_p;
    logic [31:0]      prod_hi;
    logic [6:0]       div_d;
    logic [14:0]      q0d_lo;
    logic [7:0]       rem_lo;
    logic [31:0]      q_corr;
    logic [30:0]      h_next;
    logic [47:0]      q_wide;
    logic [17:0]      q_mag;
    logic [15:0]      q_sat;
    logic [15:0]      entry;
    logic [REM_W-1:0] trem_sum;
    logic             trem_wrap;

    // quadrant fold of the table angle
    assign quad   = r_t[31:30];
    assign mirror = r_t[30] ? (wso_pkg::Q30_ONE - {1'b0, r_t[29:0]}) : {1'b0, r_t[29:0]};

    assign prod_hi = r_prod[61:30];
    assign div_d   = wso_pkg::taylor_div(r_k);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_X: begin
                mul_a = {1'b0, mirror};
                mul_b = wso_pkg::HALF_PI_Q30;
            end
            ST_X2: begin
                mul_a = {1'b0, r_prod[60:30]};
                mul_b = {1'b0, r_prod[60:30]};
            end
            ST_DM: begin
                mul_a = prod_hi;
                mul_b = wso_pkg::taylor_recip(r_k);
            end
            ST_HM: begin
                mul_a = r_x2;
                mul_b = {1'b0, r_h};
            end
            ST_SM: begin
                mul_a = {1'b0, r_x};
                mul_b = {1'b0, r_h};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // reciprocal quotient is low by at most one; remainder fits in 8 bits
    assign q0d_lo = 15'(r_prod[39:32]) * 15'(div_d);
    assign rem_lo = r_y[7:0] - q0d_lo[7:0];
    assign q_corr = r_q0 + 32'(r_rem >= {1'b0, div_d});
    assign h_next = wso_pkg::Q30_ONE - q_corr[30:0];

    // scale to q1.15 with rounding: s * 32767 + 2^29, then >> 30
    assign q_wide = {1'b0, prod_hi, 15'd0} - {16'd0, prod_hi} + 48'h0000_2000_0000;
    assign q_mag  = q_wide[47:30];
    assign q_sat  = (q_mag > 18'd32767) ? 16'd32767 : q_mag[15:0];
    assign entry  = quad[1] ? (16'd0 - q_sat) : q_sat;

    // table angle floor(i * 2^32 / period), stepped exactly
    assign trem_sum  = r_trem + T_REM;
    assign trem_wrap = (trem_sum >= T_DIV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_X;
            r_idx   <= '0;
            r_t     <= '0;
            r_trem  <= '0;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                ST_X:  r_state <= ST_X2;
                ST_X2: begin
                    r_k     <= '0;
                    r_state <= ST_DM;
                end
                ST_DM: r_state <= ST_DC;
                ST_DC: r_state <= ST_DH;
                ST_DH: r_state <= (r_k == LAST_STEP) ? ST_SM : ST_HM;
                ST_HM: begin
                    r_k     <= r_k + 3'd1;
                    r_state <= ST_DM;
                end
                ST_SM: r_state <= ST_Q;
                ST_Q: begin
                    if (r_idx == LAST_ADDR) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_idx   <= r_idx + ADDR_W'(1);
                        r_t     <= r_t + T_STEP + 32'(trem_wrap);
                        r_trem  <= trem_wrap ? (trem_sum - T_DIV) : trem_sum;
                        r_state <= ST_X;
                    end
                end
                ST_DONE: r_state <= ST_DONE;
                default: r_state <= ST_DONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_X, ST_HM, ST_SM: r_prod <= mul_p;
            ST_X2: begin
                r_x    <= r_prod[60:30];
                r_prod <= mul_p;
            end
            ST_DM: begin
                r_y <= prod_hi;
                if (r_k == 3'd0) begin
                    r_x2 <= prod_hi;
                end
                r_prod <= mul_p;
            end
            ST_DC: begin
                r_q0  <= r_prod[63:32];
                r_rem <= rem_lo;
            end
            ST_DH:   r_h <= h_next;
            default: ;
        endcase
    end

    assign o_wr_en   = (r_state == ST_Q);
    assign o_wr_addr = r_idx;
    assign o_wr_data = entry;
    assign o_done    = (r_state == ST_DONE);

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (o_wr_addr <= LAST_ADDR))
        else $error("table write beyond guard entry");

    a_done_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> o_done)
        else $error("table build restarted without reset");

endmodule

// ===== hw/rtl/wavetable_sine_oscillator_core.sv =====
// top level of the wavetable sine oscillator: config registers, phase accumulator,
// table read, interpolation and gain; depends on wso_pkg, wso_ram, wso_rom_fill
//
// Numerically controlled sine oscillator. Every word on the input stream yields one
// Q1.15 sample on the output stream, together with the 32-bit phase it was taken at.
// The top bits of the phase pick an entry of a sine table of TABLE_PERIOD entries
// plus a guard entry, the low bits interpolate linearly to the next entry, and the
// result is scaled by the signed Q1.15 amplitude with rounding and saturation. The
// phase then advances by the signed phase_step, wrapping at one period, so negative
// steps run backwards; bit 0 of the input word reloads start_phase first. After
// reset the table is computed into its ram one entry at a time, and the block takes
// no word until the table is built; config writes are taken during that time. Once
// running, the phase scale is registered at the accepting edge, then the table ram
// read, interpolation multiply, rounding add, gain multiply and the output stage
// follow in that order, each registered; the output stage holds while the previous
// result has not been taken. The next word is accepted the cycle after the result
// is loaded, so the block takes no new word while one is still in the pipeline.
module wavetable_sine_oscillator_core #(
    parameter int unsigned TABLE_PERIOD = wso_pkg::DEF_TABLE_PERIOD
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_we,
    input  logic [wso_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [wso_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [0] restart, [7:1] zero

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [47:0]                      m_axis_tdata    // [15:0] sample, [47:16] phase_now
);

    typedef enum logic [2:0] {
        ST_FILL, ST_IDLE, ST_RD, ST_MF, ST_IP, ST_GN, ST_OUT
    } t_run_state;

    localparam int unsigned ADDR_W   = $clog2(TABLE_PERIOD + 1);
    localparam int unsigned IDX_W    = $clog2(TABLE_PERIOD);
    localparam int unsigned SCALED_W = wso_pkg::PHASE_W + ADDR_W;

    // configuration
    logic signed [31:0] r_step;
    logic signed [15:0] r_amp;
    logic [31:0]        r_start;

    // control
    t_run_state  r_state;
    logic [31:0] r_acc;
    logic        r_m_valid;

    // datapath
    logic [31:0]          r_phase;
    logic [SCALED_W-1:0]  r_scaled;
    logic signed [15:0]   r_a;
    logic signed [49:0]   r_dv;
    logic signed [15:0]   r_interp;
    logic signed [31:0]   r_gain;
    logic [15:0]          r_out_sample;
    logic [31:0]          r_out_phase;

    // table build and ram
    logic                            fill_we;
    logic [ADDR_W-1:0]               fill_addr;
    logic [wso_pkg::SAMPLE_W-1:0]    fill_data;
    logic                            fill_done;
    logic [ADDR_W-1:0]               raddr_a;
    logic [ADDR_W-1:0]               raddr_b;
    logic [wso_pkg::SAMPLE_W-1:0]    rdata_a;
    logic [wso_pkg::SAMPLE_W-1:0]    rdata_b;

    logic                  accept;
    logic                  out_free;
    logic [31:0]           phase_sel;
    logic [SCALED_W-1:0]   scaled_next;
    logic [IDX_W-1:0]      idx;
    logic [31:0]           frac;
    logic signed [16:0]    diff;
    logic signed [49:0]    dv_next;
    logic signed [49:0]    dv_round;
    logic signed [17:0]    interp_sum;
    logic signed [31:0]    gain_next;
    logic signed [32:0]    gain_round;
    logic signed [17:0]    res_wide;
    logic [15:0]           res_sat;

    wso_rom_fill #(
        .TABLE_PERIOD (TABLE_PERIOD)
    ) u_fill (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_wr_en   (fill_we),
        .o_wr_addr (fill_addr),
        .o_wr_data (fill_data),
        .o_done    (fill_done)
    );

    wso_ram #(
        .WIDTH (wso_pkg::SAMPLE_W),
        .DEPTH (TABLE_PERIOD + 1)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (fill_we),
        .i_waddr   (fill_addr),
        .i_wdata   (fill_data),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // config writes; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_amp   <= wso_pkg::AMP_RESET;
            r_start <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                wso_pkg::CFG_PHASE_STEP:  r_step  <= i_cfg_wdata;
                wso_pkg::CFG_AMPLITUDE:   r_amp   <= i_cfg_wdata[15:0];
                wso_pkg::CFG_START_PHASE: r_start <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    // phase for this sample and its table position: index in the high part,
    // interpolation fraction in the low 32 bits
    assign phase_sel   = s_axis_tdata[0] ? r_start : r_acc;
    assign scaled_next = SCALED_W'(phase_sel) * SCALED_W'(TABLE_PERIOD);
    assign idx         = r_scaled[32 +: IDX_W];
    assign frac        = r_scaled[31:0];
    assign raddr_a     = ADDR_W'(idx);
    assign raddr_b     = ADDR_W'(idx) + ADDR_W'(1);

    // (b - a) * frac, then a + round-half-up of that over 2^32
    assign diff       = $signed({rdata_b[15], rdata_b}) - $signed({rdata_a[15], rdata_a});
    assign dv_next    = 50'(diff) * 50'($signed({1'b0, frac}));
    assign dv_round   = r_dv + 50'sh0_0000_8000_0000;
    assign interp_sum = $signed({{2{r_a[15]}}, r_a}) + dv_round[49:32];

    // gain, round half up at bit 15, saturate
    assign gain_next  = 32'(r_interp) * 32'(r_amp);
    assign gain_round = $signed({r_gain[31], r_gain}) + 33'sd16384;
    assign res_wide   = gain_round[32:15];
    assign res_sat    = (res_wide > 18'sd32767)  ? 16'h7fff :
                        (res_wide < -18'sd32768) ? 16'h8000 : res_wide[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_acc     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // output word is loaded from the result stage or cleared once taken
            if (r_state == ST_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_FILL: begin
                    if (fill_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_acc   <= phase_sel + $unsigned(r_step);
                        r_state <= ST_RD;
                    end
                end
                ST_RD: r_state <= ST_MF;
                ST_MF: r_state <= ST_IP;
                ST_IP: r_state <= ST_GN;
                ST_GN: r_state <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_phase  <= phase_sel;
                    r_scaled <= scaled_next;
                end
            end
            ST_MF: begin
                r_a  <= rdata_a;
                r_dv <= dv_next;
            end
            ST_IP: r_interp <= interp_sum[15:0];
            ST_GN: r_gain   <= gain_next;
            ST_OUT: begin
                if (out_free) begin
                    r_out_sample <= res_sat;
                    r_out_phase  <= r_phase;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_out_phase, r_out_sample};

    a_ready_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> fill_done)
        else $error("input taken before the sine table is built");

    a_acc_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !s_axis_tdata[0]) |=> (r_acc == $past(r_acc) + $unsigned($past(r_step))))
        else $error("phase accumulator did not advance by the step");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_m_valid && !m_axis_tready) |=> (r_state == ST_OUT))
        else $error("result stage left while the output word was still pending");

endmodule

// ===== bench/tb_wavetable_sine_oscillator_core.sv =====
`timescale 1ns / 100ps
// self-checking bench for wavetable_sine_oscillator_core: directed and random words
// against an in-bench sine oscillator predictor; depends on wso_pkg and the core rtl
module tb_wavetable_sine_oscillator_core;

    localparam int TABLE_LEN = int'(wso_pkg::DEF_TABLE_PERIOD);
    localparam logic [wso_pkg::CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;   // no register behind it
    localparam int WATCHDOG_LIMIT = 100000;   // outlasts the quiet table fill after reset
    localparam int HOLD_CYCLES    = 200;
    localparam int MAX_REPORTS    = 10;

    localparam longint unsigned Q30     = 64'd1 << 30;
    localparam longint unsigned HALF_PI = 64'd1686629713;   // pi/2 in q30

    typedef struct packed {
        logic signed [wso_pkg::SAMPLE_W-1:0] level;
        logic [wso_pkg::PHASE_W-1:0]         phase;
    } t_osc_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                           cfg_we = 1'b0;
    logic [wso_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [wso_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;    // [0] restart, [7:1] zero

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // [15:0] sample, [47:16] phase_now

    // predictor state: registers, accumulator and the sine table
    logic [wso_pkg::PHASE_W-1:0]         osc_step  = '0;
    logic signed [wso_pkg::AMP_W-1:0]    osc_gain  = wso_pkg::AMP_RESET;
    logic [wso_pkg::PHASE_W-1:0]         osc_start = '0;
    logic [wso_pkg::PHASE_W-1:0]         osc_phase = '0;
    logic signed [wso_pkg::SAMPLE_W-1:0] sine_tab [0:TABLE_LEN];

    t_osc_word expected_words[$];

    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    logic rx_hold = 1'b0;
    int fault_count = 0;
    int quiet_cycles = 0;

    wavetable_sine_oscillator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // one table entry at phase t: fold into the first quadrant, then horner form of
    // the taylor series in q30, then round to q1.15 and restore the sign
    function automatic logic signed [wso_pkg::SAMPLE_W-1:0] sine_entry(
            input longint unsigned t);
        longint unsigned quad, r, x, x2, h, s, q;
        quad = t >> 30;
        r = t & (Q30 - 1);
        if (quad == 1 || quad == 3) begin
            r = Q30 - r;
        end
        x  = (r * HALF_PI) >> 30;
        x2 = (x * x) >> 30;
        h  = Q30 - x2 / 110;
        h  = Q30 - ((x2 * h) >> 30) / 72;
        h  = Q30 - ((x2 * h) >> 30) / 42;
        h  = Q30 - ((x2 * h) >> 30) / 20;
        h  = Q30 - ((x2 * h) >> 30) / 6;
        s  = (x * h) >> 30;
        q  = (s * 32767 + (64'd1 << 29)) >> 30;
        if (q > 32767) begin
            q = 32767;
        end
        return (quad >= 2) ? wso_pkg::SAMPLE_W'(-q) : wso_pkg::SAMPLE_W'(q);
    endfunction

    // expected word for one accepted input word; advances the accumulator
    function automatic t_osc_word next_sample(input logic restart);
        longint unsigned scaled, idx;
        longint a, b, frac, v, interp, p, res;
        t_osc_word w;
        if (restart) begin
            osc_phase = osc_start;
        end
        scaled = 64'(osc_phase) * 64'(TABLE_LEN);
        idx = scaled >> 32;
        if (idx > TABLE_LEN - 1) begin
            idx = TABLE_LEN - 1;
        end
        frac = longint'(scaled & 64'hFFFF_FFFF);
        a = longint'(sine_tab[idx]);
        b = longint'(sine_tab[idx + 1]);
        // linear blend, rounded half up back to q1.15
        v = a * 64'sh1_0000_0000 + (b - a) * frac;
        interp = (v + 64'sd2147483648) >>> 32;
        // gain in q1.15 with rounding and saturation
        p = interp * longint'(osc_gain);
        res = (p + 64'sd16384) >>> 15;
        if (res > 32767) begin
            res = 32767;
        end else if (res < -32768) begin
            res = -32768;
        end
        w.level = res[wso_pkg::SAMPLE_W-1:0];
        w.phase = osc_phase;
        osc_phase = osc_phase + osc_step;
        return w;
    endfunction

    function automatic void report_fault(input string what, input logic [47:0] want,
                                         input logic [47:0] got);
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endfunction

    // output side: check each taken word, then pick tready for the next cycle
    always @(posedge i_clk) begin
        t_osc_word want;
        if (m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_fault("unexpected word", '0, m_tdata);
            end else begin
                want = expected_words.pop_front();
                if (m_tdata[15:0] !== want.level) begin
                    report_fault("sample", 48'(want.level), 48'(m_tdata[15:0]));
                end
                if (m_tdata[47:16] !== want.phase) begin
                    report_fault("phase_now", 48'(want.phase), 48'(m_tdata[47:16]));
                end
            end
        end
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // watchdog: ends the run when no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[wavetable_sine_oscillator_core] ERROR");
                $finish;
            end
        end
    end

    // offer one word, with random idle cycles first; predict once it is taken
    task automatic send_word(input logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        do @(posedge i_clk); while (!s_tready);
        expected_words.push_back(next_sample(restart));
    endtask

    // stop offering and wait until every predicted word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    task automatic write_reg(input logic [wso_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            wso_pkg::CFG_PHASE_STEP:  osc_step  = value;
            wso_pkg::CFG_AMPLITUDE:   osc_gain  = value[wso_pkg::AMP_W-1:0];
            wso_pkg::CFG_START_PHASE: osc_start = value;
            default: ;   // unused index, write has no effect
        endcase
    endtask

    // reset values: step 0 keeps phase 0, which gives a zero sample
    task automatic test_reset_defaults();
        send_word(1'b0);
        send_word(1'b1);
        drain();
    endtask

    task automatic test_step_extremes();
        write_reg(wso_pkg::CFG_START_PHASE, 32'h0000_0000);
        write_reg(wso_pkg::CFG_PHASE_STEP, 32'h7FFF_FFFF);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);
        drain();
        // most negative step runs backwards by half a period
        write_reg(wso_pkg::CFG_PHASE_STEP, 32'h8000_0000);
        send_word(1'b0);
        send_word(1'b0);
        drain();
    endtask

    task automatic test_gain_extremes();
        write_reg(wso_pkg::CFG_PHASE_STEP, 32'h0000_0000);
        // gain -1.0 at the trough of the wave, product turns positive
        write_reg(wso_pkg::CFG_AMPLITUDE, 32'h0000_8000);
        write_reg(wso_pkg::CFG_START_PHASE, 32'hC000_0000);
        send_word(1'b1);
        drain();
        write_reg(wso_pkg::CFG_AMPLITUDE, 32'h0000_0000);
        send_word(1'b0);
        drain();
        // full gain at the peak
        write_reg(wso_pkg::CFG_AMPLITUDE, 32'h0000_7FFF);
        write_reg(wso_pkg::CFG_START_PHASE, 32'h4000_0000);
        send_word(1'b1);
        drain();
    endtask

    // accumulator rolls over from the top of the period back to zero
    task automatic test_phase_wrap();
        write_reg(wso_pkg::CFG_START_PHASE, 32'hFFFF_FFFF);
        write_reg(wso_pkg::CFG_PHASE_STEP, 32'h0000_0001);
        send_word(1'b1);
        send_word(1'b0);
        drain();
    endtask

    task automatic test_unused_index();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_word(1'b0);
        send_word(1'b1);
        drain();
    endtask

    // output held off for a long stretch while the input keeps offering words
    task automatic test_output_hold();
        send_idle_pct = 0;
        write_reg(wso_pkg::CFG_PHASE_STEP, 32'h0012_3457);
        rx_hold = 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        repeat (12) send_word(1'($urandom_range(1)));
        drain();
    endtask

    // bursts of words with random register writes between bursts
    task automatic test_random_bursts(input int send_pct, input int stall_pct,
                                      input int n_words);
        int sent;
        int burst;
        logic [31:0] value;
        send_idle_pct = send_pct;
        rx_stall_pct  = stall_pct;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(5))
                    0: value = 32'($signed($urandom_range(8192)) - 4096);
                    1: value = $urandom();
                    2: value = 32'h7FFF_FFFF;
                    3: value = 32'h8000_0000;
                    4: value = 32'($urandom_range(TABLE_LEN - 1)) << 22;
                    default: value = 32'($urandom_range(1 << 20));
                endcase
                write_reg(wso_pkg::CFG_PHASE_STEP, value);
            end
            if ($urandom_range(2) != 0) begin
                case ($urandom_range(4))
                    0: value = 32'h0000_7FFF;
                    1: value = 32'h0000_8000;
                    2: value = 32'h0000_0000;
                    3: value = $urandom();   // upper bits are dropped by the register
                    default: value = 32'($signed(16'($urandom())));
                endcase
                write_reg(wso_pkg::CFG_AMPLITUDE, value);
            end
            if ($urandom_range(2) != 0) begin
                case ($urandom_range(3))
                    0: value = 32'h0000_0000;
                    1: value = 32'hFFFF_FFFF;
                    2: value = 32'($urandom_range(3)) << 30;
                    default: value = $urandom();
                endcase
                write_reg(wso_pkg::CFG_START_PHASE, value);
            end
            if ($urandom_range(15) == 0) begin
                write_reg(CFG_UNUSED, $urandom());
            end
            burst = $urandom_range(8, 40);
            if (burst > n_words - sent) begin
                burst = n_words - sent;
            end
            repeat (burst) send_word($urandom_range(7) == 0);
            sent += burst;
            drain();
        end
    endtask

    initial begin
        for (int i = 0; i < TABLE_LEN; i++) begin
            sine_sine_fill: sine_tab[i] = sine_entry((64'(i) << 32) / 64'(TABLE_LEN));
        end
        sine_tab[TABLE_LEN] = sine_tab[0];

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part with the sender idling lightly and the receiver heavily
        send_idle_pct = 20;
        rx_stall_pct  = 66;
        test_reset_defaults();
        test_step_extremes();
        test_gain_extremes();
        test_phase_wrap();
        test_unused_index();
        test_output_hold();

        test_random_bursts(20, 66, 310);
        test_random_bursts(66, 20, 310);
        test_random_bursts(0, 0, 310);

        drain();
        repeat (20) @(posedge i_clk);
        if (fault_count == 0 && expected_words.size() == 0) begin
            $display("[wavetable_sine_oscillator_core] OK");
        end else begin
            $display("[wavetable_sine_oscillator_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/wso_pkg.sv
hw/rtl/wso_ram.sv
hw/rtl/wso_rom_fill.sv
hw/rtl/wavetable_sine_oscillator_core.sv
bench/tb_wavetable_sine_oscillator_core.sv
